@@ rtl/vbbd_pkg.sv @@
// shared constants, types and state encoding of the voxel box blur density core
package vbbd_pkg;

  localparam int GridXDefault = 32;
  localparam int GridYDefault = 32;
  localparam int GridZDefault = 32;

  localparam int PosW   = 5;
  localparam int CountW = 7;
  localparam int DensW  = 16;
  localparam int PopW   = 3;
  localparam int SpanW  = 3;
  localparam int CoordW = 9;

  localparam int KernelHalf = 2;
  localparam int KernelSpan = 2 * KernelHalf + 1;

  // floor(c * 65536 / 216) == (c * DensityMul) >> DensityShift for c <= 125
  localparam int MulW = 21;
  localparam logic [MulW-1:0] DensityMul = 21'd1242757;
  localparam int DensityShift = 12;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_READ,
    ST_WR_WRITE,
    ST_Q_RUN,
    ST_Q_DRAIN,
    ST_Q_MUL,
    ST_Q_LOAD
  } vbbd_state_e;

  typedef struct packed {
    logic capture;
    logic clr_we;
    logic wr_read;
    logic wr_write;
    logic q_issue;
    logic mul;
    logic load;
  } vbbd_cmd_t;

  typedef struct packed {
    logic in_query;
    logic clr_last;
    logic q_last;
    logic out_free;
  } vbbd_stat_t;

endpackage

@@ rtl/voxel_box_blur_density_core.sv @@
// top level of the voxel box blur density core
// A write transaction updates one cell of the GRID_X x GRID_Y x GRID_Z grid and returns nothing;
// it passes through accept, row read and row write back. A query transaction returns the set-cell
// count of the clipped 5x5x5 window around the voxel and that count divided by 216 as unsigned
// Q0.16. It goes through accept, 25 row reads through the single read port of the grid
// memory (one Z-wide row per cycle), a drain step, a multiply step and a load of
// the result register, which may wait while an earlier result has not been taken. After reset
// the grid memory is cleared one row per cycle before the first transaction is accepted.
module voxel_box_blur_density_core #(
  parameter int GRID_X = vbbd_pkg::GridXDefault,
  parameter int GRID_Y = vbbd_pkg::GridYDefault,
  parameter int GRID_Z = vbbd_pkg::GridZDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [vbbd_pkg::PosW-1:0]   pos_x_i,
  input  logic [vbbd_pkg::PosW-1:0]   pos_y_i,
  input  logic [vbbd_pkg::PosW-1:0]   pos_z_i,
  input  logic                        cell_bit_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [vbbd_pkg::CountW-1:0] cloud_count_o,
  output logic [vbbd_pkg::DensW-1:0]  density_q16_o
);
  import vbbd_pkg::*;

  vbbd_cmd_t  cmd;
  vbbd_stat_t stat;

  vbbd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  vbbd_dp #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .func_i       (func_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .cell_bit_i   (cell_bit_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cloud_count_o(cloud_count_o),
    .density_q16_o(density_q16_o)
  );

endmodule

@@ rtl/vbbd_ram.sv @@
// generic simple dual-port ram with registered read
module vbbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/vbbd_ctrl.sv @@
// controller state machine sequencing clear, write and query transactions
module vbbd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vbbd_pkg::vbbd_stat_t stat_i,
  output vbbd_pkg::vbbd_cmd_t  cmd_o
);
  import vbbd_pkg::*;

  vbbd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = stat_i.in_query ? ST_Q_RUN : ST_WR_READ;
      end
      ST_WR_READ:  state_d = ST_WR_WRITE;
      ST_WR_WRITE: state_d = ST_IDLE;
      ST_Q_RUN: begin
        if (stat_i.q_last) state_d = ST_Q_DRAIN;
      end
      ST_Q_DRAIN: state_d = ST_Q_MUL;
      ST_Q_MUL:   state_d = ST_Q_LOAD;
      ST_Q_LOAD: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    cmd_o          = '0;
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.clr_we   = (state_q == ST_CLEAR);
    cmd_o.wr_read  = (state_q == ST_WR_READ);
    cmd_o.wr_write = (state_q == ST_WR_WRITE);
    cmd_o.q_issue  = (state_q == ST_Q_RUN);
    cmd_o.mul      = (state_q == ST_Q_MUL);
    cmd_o.load     = (state_q == ST_Q_LOAD) && stat_i.out_free;
  end

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_write |-> $past(cmd_o.wr_read))
    else $error("row write without preceding row read");

  a_last_issue_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.q_issue && stat_i.q_last |=> state_q == ST_Q_DRAIN)
    else $error("query did not drain after last row");

  a_mul_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul |-> $past(state_q) == ST_Q_DRAIN)
    else $error("density computed before window complete");

endmodule

@@ rtl/vbbd_dp.sv @@
// datapath: grid row storage, window row walk, slice popcount, density and result register
module vbbd_dp #(
  parameter int GRID_X = vbbd_pkg::GridXDefault,
  parameter int GRID_Y = vbbd_pkg::GridYDefault,
  parameter int GRID_Z = vbbd_pkg::GridZDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vbbd_pkg::vbbd_cmd_t           cmd_i,
  output vbbd_pkg::vbbd_stat_t          stat_o,
  input  logic                          func_i,
  input  logic [vbbd_pkg::PosW-1:0]     pos_x_i,
  input  logic [vbbd_pkg::PosW-1:0]     pos_y_i,
  input  logic [vbbd_pkg::PosW-1:0]     pos_z_i,
  input  logic                          cell_bit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vbbd_pkg::CountW-1:0]   cloud_count_o,
  output logic [vbbd_pkg::DensW-1:0]    density_q16_o
);
  import vbbd_pkg::*;

  localparam int Depth = GRID_X * GRID_Y;
  localparam int AW    = $clog2(Depth);
  localparam int XIW   = $clog2(GRID_X);
  localparam int YIW   = $clog2(GRID_Y);
  localparam int ZIW   = $clog2(GRID_Z);
  localparam int ProdW = CountW + MulW;
  localparam logic [SpanW-1:0] SpanLast = SpanW'(KernelSpan - 1);
  localparam logic [CoordW-1:0] Half = CoordW'(KernelHalf);

  logic                func_q, bit_q;
  logic [PosW-1:0]     px_q, py_q, pz_q;
  logic [SpanW-1:0]    ci_q, ci_d, cj_q, cj_d;
  logic                rd_pend_q, rd_pend_d, row_ok_q, row_ok_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [DensW-1:0]    dens_q;
  logic                out_valid_q, out_valid_d;
  logic [CountW-1:0]   out_count_q;
  logic [DensW-1:0]    out_dens_q;
  logic [AW-1:0]       clr_addr_q;

  logic [CoordW-1:0]   xu, yu, xo, yo;
  logic                xv, yv, item_ok;
  logic [AW-1:0]       q_addr, w_addr, raddr;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr;
  logic [GRID_Z-1:0]   ram_wdata, rdata, mod_row;
  logic [PopW-1:0]     pop;
  logic [ProdW-1:0]    prod;

  vbbd_ram #(
    .WIDTH(GRID_Z),
    .DEPTH(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // window row coordinates, offset by the half-width
  always_comb begin
    xu = CoordW'(px_q) + CoordW'(ci_q);
    yu = CoordW'(py_q) + CoordW'(cj_q);
    xo = xu - Half;
    yo = yu - Half;
    xv = (xu >= Half) && (xo < CoordW'(GRID_X));
    yv = (yu >= Half) && (yo < CoordW'(GRID_Y));
    q_addr = AW'(xo[XIW-1:0]) * AW'(GRID_Y) + AW'(yo[YIW-1:0]);
    w_addr = AW'(px_q) * AW'(GRID_Y) + AW'(py_q);
    item_ok = (CoordW'(px_q) < CoordW'(GRID_X)) && (CoordW'(py_q) < CoordW'(GRID_Y))
           && (CoordW'(pz_q) < CoordW'(GRID_Z));
  end

  assign raddr  = cmd_i.q_issue ? q_addr : w_addr;
  assign ram_re = cmd_i.q_issue || cmd_i.wr_read;

  always_comb begin
    for (int z = 0; z < GRID_Z; z++) begin
      mod_row[z] = (CoordW'(z) == CoordW'(pz_q)) ? bit_q : rdata[z];
    end
  end

  always_comb begin
    ram_we    = cmd_i.clr_we || (cmd_i.wr_write && item_ok);
    ram_waddr = cmd_i.clr_we ? clr_addr_q : w_addr;
    ram_wdata = cmd_i.clr_we ? '0 : mod_row;
  end

  // clipped five-cell slice of the returned row
  always_comb begin
    logic [CoordW-1:0] zu, zo;
    logic              zv;
    pop = '0;
    for (int k = 0; k < KernelSpan; k++) begin
      zu = CoordW'(pz_q) + CoordW'(k);
      zo = zu - Half;
      zv = (zu >= Half) && (zo < CoordW'(GRID_Z));
      if (zv && rdata[zo[ZIW-1:0]]) pop = pop + PopW'(1);
    end
  end

  always_comb begin
    ci_d      = ci_q;
    cj_d      = cj_q;
    rd_pend_d = cmd_i.q_issue;
    row_ok_d  = xv && yv;
    count_d   = count_q;
    if (rd_pend_q && row_ok_q) count_d = count_q + CountW'(pop);
    if (cmd_i.q_issue) begin
      if (cj_q == SpanLast) begin
        cj_d = '0;
        ci_d = ci_q + SpanW'(1);
      end else begin
        cj_d = cj_q + SpanW'(1);
      end
    end
    if (cmd_i.capture) begin
      ci_d    = '0;
      cj_d    = '0;
      count_d = '0;
    end
  end

  assign prod = ProdW'(count_q) * ProdW'(DensityMul);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.load)  out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ci_q        <= '0;
      cj_q        <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      clr_addr_q  <= '0;
    end else begin
      ci_q        <= ci_d;
      cj_q        <= cj_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.clr_we) clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pz_q   <= pos_z_i;
      bit_q  <= cell_bit_i;
    end
    row_ok_q <= row_ok_d;
    count_q  <= count_d;
    if (cmd_i.mul) dens_q <= prod[DensityShift +: DensW];
    if (cmd_i.load) begin
      out_count_q <= count_q;
      out_dens_q  <= dens_q;
    end
  end

  always_comb begin
    stat_o.in_query = (func_i == FuncQuery);
    stat_o.clr_last = (clr_addr_q == AW'(Depth - 1));
    stat_o.q_last   = (ci_q == SpanLast) && (cj_q == SpanLast);
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign cloud_count_o = out_count_q;
  assign density_q16_o = out_dens_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !out_valid_q || out_ready_i)
    else $error("pending result overwritten");

  a_capture_inits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |=> ci_q == '0 && cj_q == '0 && count_q == '0)
    else $error("window walk not restarted");

  a_write_item_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_read |-> func_q == FuncWrite)
    else $error("row update on a query transaction");

endmodule

@@ tb/testbench.sv @@
// testbench for the voxel box blur density core: directed corners, full window, clustered random, receiver hold
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vbbd_pkg::*;

  localparam int GridN      = 32;
  localparam int KernelDiv  = 216;
  localparam int StallLimit = 4000;
  localparam int DrainWait  = 40;
  localparam int HoldCycles = 300;
  localparam int ExpDepth   = 16;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [DensW-1:0]  dens;
  } blur_result_t;

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              func_i = FuncWrite;
  logic [PosW-1:0]   pos_x_i = '0;
  logic [PosW-1:0]   pos_y_i = '0;
  logic [PosW-1:0]   pos_z_i = '0;
  logic              cell_bit_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CountW-1:0] cloud_count_o;
  logic [DensW-1:0]  density_q16_o;

  bit           cloud_cells [GridN][GridN][GridN];
  blur_result_t expected_blur [ExpDepth];
  int           exp_wr_cnt = 0;
  int           exp_rd_cnt = 0;
  blur_result_t head_res;
  int           err_cnt = 0;
  int           quiet_cycles = 0;
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;
  int           hold_req_cnt = 0;
  int           hold_seen_cnt = 0;
  int           rx_hold_cycles = 0;
  int           rx_stall_cnt = 0;

  voxel_box_blur_density_core DUT (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .cell_bit_i    (cell_bit_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cloud_count_o (cloud_count_o),
    .density_q16_o (density_q16_o)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // one transaction on the input channel, prediction on acceptance
  task automatic send_item(input logic f, input int x, input int y, input int z, input logic b);
    int gap;
    int dx;
    int dy;
    int dz;
    int unsigned cnt;
    blur_result_t res;
    gap = (tx_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i = 1'b1;
    func_i     = f;
    pos_x_i    = x[PosW-1:0];
    pos_y_i    = y[PosW-1:0];
    pos_z_i    = z[PosW-1:0];
    cell_bit_i = b;
    do @(posedge clk); while (!in_ready_o);
    if (f == FuncWrite) begin
      cloud_cells[x][y][z] = b;
    end else begin
      cnt = 0;
      for (dx = x - KernelHalf; dx <= x + KernelHalf; dx++) begin
        for (dy = y - KernelHalf; dy <= y + KernelHalf; dy++) begin
          for (dz = z - KernelHalf; dz <= z + KernelHalf; dz++) begin
            if (dx >= 0 && dx < GridN && dy >= 0 && dy < GridN && dz >= 0 && dz < GridN) begin
              if (cloud_cells[dx][dy][dz]) cnt++;
            end
          end
        end
      end
      res.count = cnt[CountW-1:0];
      res.dens  = DensW'((cnt * 65536) / KernelDiv);
      expected_blur[exp_wr_cnt % ExpDepth] = res;
      exp_wr_cnt++;
    end
  endtask

  function automatic int near_pos(input int c, input int r);
    int v;
    v = c + $urandom_range(0, 2 * r) - r;
    if (v < 0) v = 0;
    if (v > GridN - 1) v = GridN - 1;
    return v;
  endfunction

  task automatic test_directed();
    send_item(FuncQuery, 0, 0, 0, 1'b0);
    send_item(FuncQuery, 31, 31, 31, 1'b1);
    send_item(FuncWrite, 0, 0, 0, 1'b1);
    send_item(FuncWrite, 31, 31, 31, 1'b1);
    send_item(FuncWrite, 0, 31, 0, 1'b1);
    send_item(FuncWrite, 31, 0, 31, 1'b1);
    send_item(FuncQuery, 0, 0, 0, 1'b0);
    send_item(FuncQuery, 31, 31, 31, 1'b0);
    send_item(FuncQuery, 2, 2, 2, 1'b1);
    send_item(FuncQuery, 3, 3, 3, 1'b0);
    send_item(FuncQuery, 29, 29, 29, 1'b0);
    send_item(FuncQuery, 0, 31, 0, 1'b1);
    send_item(FuncQuery, 31, 0, 31, 1'b0);
    send_item(FuncQuery, 1, 30, 1, 1'b0);
    send_item(FuncWrite, 0, 0, 0, 1'b0);
    send_item(FuncWrite, 15, 15, 15, 1'b0);
    send_item(FuncQuery, 0, 0, 0, 1'b1);
    send_item(FuncQuery, 15, 15, 15, 1'b1);
    send_item(FuncWrite, 16, 15, 14, 1'b1);
    send_item(FuncQuery, 14, 17, 16, 1'b0);
    send_item(FuncQuery, 13, 15, 15, 1'b0);
  endtask

  task automatic test_full_window();
    int x;
    int y;
    int z;
    for (x = 8; x <= 12; x++)
      for (y = 8; y <= 12; y++)
        for (z = 8; z <= 12; z++)
          send_item(FuncWrite, x, y, z, 1'b1);
    send_item(FuncQuery, 10, 10, 10, 1'b0);
    send_item(FuncQuery, 12, 12, 12, 1'b1);
    send_item(FuncQuery, 14, 10, 10, 1'b0);
    send_item(FuncQuery, 15, 10, 10, 1'b0);
  endtask

  // bursts of writes and queries around one center, with some random noise items
  task automatic test_cluster_random(input int n_items);
    int sent;
    int burst;
    int cx;
    int cy;
    int cz;
    int k;
    sent = 0;
    while (sent < n_items) begin
      cx = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? GridN - 1 : 0)
                                     : $urandom_range(0, 31);
      cy = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? GridN - 1 : 0)
                                     : $urandom_range(0, 31);
      cz = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? GridN - 1 : 0)
                                     : $urandom_range(0, 31);
      burst = $urandom_range(8, 30);
      for (k = 0; k < burst; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(logic'($urandom_range(0, 1)), $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 31), logic'($urandom_range(0, 1)));
        end else if ($urandom_range(0, 9) < 6) begin
          send_item(FuncWrite, near_pos(cx, 2), near_pos(cy, 2), near_pos(cz, 2),
                    logic'($urandom_range(0, 9) < 7));
        end else begin
          send_item(FuncQuery, near_pos(cx, 3), near_pos(cy, 3), near_pos(cz, 3),
                    logic'($urandom_range(0, 1)));
        end
        sent++;
      end
    end
  endtask

  task automatic test_receiver_hold();
    int k;
    tx_idle_on = 1'b0;
    @(negedge clk);
    hold_req_cnt++;
    for (k = 0; k < 16; k++) begin
      send_item(FuncQuery, near_pos(10, 4), near_pos(10, 4), near_pos(10, 4),
                logic'($urandom_range(0, 1)));
    end
    tx_idle_on = 1'b1;
  endtask

  // receiver: long hold on request, random stall bursts otherwise
  always @(negedge clk) begin
    if (hold_seen_cnt != hold_req_cnt) begin
      hold_seen_cnt  = hold_req_cnt;
      rx_hold_cycles = HoldCycles;
    end
    if (rx_hold_cycles > 0) begin
      out_ready_i = 1'b0;
      rx_hold_cycles--;
    end else if (rx_stall_cnt > 0) begin
      out_ready_i = 1'b0;
      rx_stall_cnt--;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      out_ready_i = 1'b0;
      rx_stall_cnt = $urandom_range(1, 19) - 1;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_rd_cnt == exp_wr_cnt) begin
        report_mismatch("unexpected result count", int'(cloud_count_o), 0);
      end else begin
        head_res = expected_blur[exp_rd_cnt % ExpDepth];
        exp_rd_cnt++;
        if (cloud_count_o !== head_res.count)
          report_mismatch("cloud_count", int'(cloud_count_o), int'(head_res.count));
        if (density_q16_o !== head_res.dens)
          report_mismatch("density_q16", int'(density_q16_o), int'(head_res.dens));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    test_directed();
    test_full_window();
    test_cluster_random(600);
    test_receiver_hold();
    test_cluster_random(250);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_cluster_random(150);
    @(negedge clk);
    in_valid_i = 1'b0;
    while (exp_rd_cnt != exp_wr_cnt) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ voxel_box_blur_density_core.f @@
rtl/vbbd_pkg.sv
rtl/vbbd_ram.sv
rtl/vbbd_ctrl.sv
rtl/vbbd_dp.sv
rtl/voxel_box_blur_density_core.sv
tb/testbench.sv
